FILE: rtl/tagc_pkg.sv
// ----------------------------------------------------------------------------
// tagc_pkg
// Shared types and constants of the transposition, additive and gamma cipher.
// ----------------------------------------------------------------------------
package tagc_pkg;

  // Largest block and password length in bytes
  localparam int unsigned MAX_PASS_LEN = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_PASS_LEN);
  localparam int unsigned LEN_W        = IDX_W + 1;
  localparam int unsigned PW_W         = 8 * MAX_PASS_LEN;

  // Register bus
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  // Register indexes (byte address is 8 times the index)
  localparam logic [1:0] REG_PASS_LEN      = 2'd0;
  localparam logic [1:0] REG_PASSWORD_LOW  = 2'd1;
  localparam logic [1:0] REG_PASSWORD_HIGH = 2'd2;
  localparam logic [1:0] REG_DECRYPT_MODE  = 2'd3;

  // One message byte with its gamma byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] gamma_byte;
    logic       end_of_message;
  } msg_t;

  // One transformed byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_last;
  } res_t;

  // Register contents seen by the datapath
  typedef struct packed {
    logic [4:0]      pass_len;
    logic [PW_W-1:0] password;
    logic            decrypt_mode;
  } cfg_t;

endpackage

FILE: rtl/transposition_additive_gamma_cipher.sv
// ----------------------------------------------------------------------------
// transposition_additive_gamma_cipher
// Block columnar transposition keyed by the password order, with an additive
// password stage and an XOR gamma stage, on a byte stream.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  msg      | in        | msg_valid/msg_stall  | data_byte, gamma_byte, end_of_message
//  res      | out       | res_valid/res_stall  | out_byte, run_last, message_last
//  apb      | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
//  A block of L bytes is filled one transfer a cycle while the input is not
//  held off, then ranked by a pass over the password in the rank lanes, then
//  sent out as L reads through the buffer RAMs.
//  Input is held off from the block's last byte until its last RAM read.
//  Result stalls back up through a two-entry queue and pause the RAM reads.
//  Reset clears the fill count, sequencer and queue; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module transposition_additive_gamma_cipher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         msg_valid,
  output logic                         msg_stall,
  input  tagc_pkg::msg_t               msg,
  output logic                         res_valid,
  input  logic                         res_stall,
  output tagc_pkg::res_t               res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tagc_pkg::PADDR_W-1:0] paddr,
  input  logic [tagc_pkg::PDATA_W-1:0] pwdata,
  output logic [tagc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam logic [1:0] S_FILL = 2'd0;
  localparam logic [1:0] S_RANK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  tagc_pkg::cfg_t               cfg;
  logic [1:0]                   state;
  logic [tagc_pkg::LEN_W-1:0]   fill;
  logic [tagc_pkg::LEN_W-1:0]   fill_next;
  logic [tagc_pkg::LEN_W-1:0]   bsize;
  logic [tagc_pkg::LEN_W-1:0]   len;
  logic                         eom;
  logic [tagc_pkg::IDX_W-1:0]   pos;
  logic                         acc;
  logic                         flush;
  logic                         rank_done;
  logic [tagc_pkg::IDX_W-1:0]   key_idx;
  logic [tagc_pkg::IDX_W-1:0]   rank_sel;
  logic                         issue;
  logic                         issue_last;
  logic [tagc_pkg::IDX_W-1:0]   data_addr;
  logic [tagc_pkg::IDX_W-1:0]   gamma_addr;
  logic [tagc_pkg::IDX_W-1:0]   pw_idx;
  logic [7:0]                   data_rd;
  logic [7:0]                   gamma_rd;
  logic                         rd_v;
  logic [7:0]                   rd_pw;
  logic                         rd_mode;
  logic                         rd_last;
  logic                         rd_eom;
  tagc_pkg::res_t               res_next;
  logic [1:0]                   q_count;
  logic                         pop;

  tagc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective block size: zero acts as one, large values clamp
  always_comb begin
    priority if (cfg.pass_len == 5'd0) begin
      bsize = tagc_pkg::LEN_W'(1);
    end else if (cfg.pass_len > 5'(tagc_pkg::MAX_PASS_LEN)) begin
      bsize = tagc_pkg::LEN_W'(tagc_pkg::MAX_PASS_LEN);
    end else begin
      bsize = tagc_pkg::LEN_W'(cfg.pass_len);
    end
  end

  assign msg_stall = (state != S_FILL);
  assign acc       = msg_valid && !msg_stall;
  assign fill_next = fill[tagc_pkg::IDX_W] ? fill : fill + tagc_pkg::LEN_W'(1);
  assign flush     = acc && ((fill_next >= bsize) || msg.end_of_message);

  // Issue a read only when the queue has room for it on landing
  assign pop        = res_valid && !res_stall;
  assign issue      = (state == S_EMIT) &&
                      (({1'b0, q_count} + {2'b0, rd_v}) <= (3'd1 + {2'b0, pop}));
  assign issue_last = ({1'b0, pos} == len - tagc_pkg::LEN_W'(1));

  // Sequencer: fill, rank, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill  <= '0;
    end else begin
      unique case (state)
        S_FILL: begin
          if (flush) begin
            fill  <= '0;
            state <= S_RANK;
          end else if (acc) begin
            fill <= fill_next;
          end
        end
        S_RANK: begin
          if (rank_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue && issue_last) begin
            state <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  // Block length, end flag and output position
  always_ff @(posedge clk) begin
    if (flush) begin
      len <= fill_next;
      eom <= msg.end_of_message;
    end
    if (rank_done) begin
      pos <= '0;
    end else if (issue) begin
      pos <= pos + tagc_pkg::IDX_W'(1);
    end
  end

  tagc_rank u_rank (
    .clk      (clk),
    .rst      (rst),
    .start    (flush),
    .len      (len),
    .password (cfg.password),
    .pos      (pos),
    .done     (rank_done),
    .key_idx  (key_idx),
    .rank_sel (rank_sel)
  );

  // Read addresses for the two directions
  always_comb begin
    if (cfg.decrypt_mode) begin
      data_addr  = rank_sel;
      gamma_addr = rank_sel;
      pw_idx     = rank_sel;
    end else begin
      data_addr  = key_idx;
      gamma_addr = pos;
      pw_idx     = pos;
    end
  end

  tagc_ram #(.WIDTH(8), .DEPTH(tagc_pkg::MAX_PASS_LEN)) u_data_ram (
    .clk   (clk),
    .we    (acc && !fill[tagc_pkg::IDX_W]),
    .waddr (fill[tagc_pkg::IDX_W-1:0]),
    .wdata (msg.data_byte),
    .re    (issue),
    .raddr (data_addr),
    .rdata (data_rd)
  );

  tagc_ram #(.WIDTH(8), .DEPTH(tagc_pkg::MAX_PASS_LEN)) u_gamma_ram (
    .clk   (clk),
    .we    (acc && !fill[tagc_pkg::IDX_W]),
    .waddr (fill[tagc_pkg::IDX_W-1:0]),
    .wdata (msg.gamma_byte),
    .re    (issue),
    .raddr (gamma_addr),
    .rdata (gamma_rd)
  );

  // Carry the per-byte control alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_pw   <= cfg.password[{pw_idx, 3'b000} +: 8];
      rd_mode <= cfg.decrypt_mode;
      rd_last <= issue_last;
      rd_eom  <= issue_last && eom;
    end
  end

  // Additive and gamma stage on the read data
  always_comb begin
    if (rd_mode) begin
      res_next.out_byte = (data_rd ^ gamma_rd) - rd_pw;
    end else begin
      res_next.out_byte = (data_rd + rd_pw) ^ gamma_rd;
    end
    res_next.run_last     = rd_last;
    res_next.message_last = rd_eom;
  end

  tagc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_v),
    .push_data (res_next),
    .pop       (pop),
    .count     (q_count),
    .head      (res)
  );

  assign res_valid = (q_count != 2'd0);

endmodule

FILE: rtl/tagc_ram.sv
// ----------------------------------------------------------------------------
// tagc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tagc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tagc_cfg.sv
// ----------------------------------------------------------------------------
// tagc_cfg
// Register block on the APB-style port: block length, password, direction.
// ----------------------------------------------------------------------------
module tagc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tagc_pkg::PADDR_W-1:0]   paddr,
  input  logic [tagc_pkg::PDATA_W-1:0]   pwdata,
  output logic [tagc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output tagc_pkg::cfg_t                 cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[4:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pass_len     <= 5'd1;
      cfg.password     <= '0;
      cfg.decrypt_mode <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        tagc_pkg::REG_PASS_LEN:      cfg.pass_len        <= pwdata[4:0];
        tagc_pkg::REG_PASSWORD_LOW:  cfg.password[63:0]  <= pwdata;
        tagc_pkg::REG_PASSWORD_HIGH: cfg.password[127:64] <= pwdata;
        tagc_pkg::REG_DECRYPT_MODE:  cfg.decrypt_mode    <= pwdata[0];
        default:                     cfg.decrypt_mode    <= cfg.decrypt_mode;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      tagc_pkg::REG_PASS_LEN:      prdata = {59'd0, cfg.pass_len};
      tagc_pkg::REG_PASSWORD_LOW:  prdata = cfg.password[63:0];
      tagc_pkg::REG_PASSWORD_HIGH: prdata = cfg.password[127:64];
      tagc_pkg::REG_DECRYPT_MODE:  prdata = {63'd0, cfg.decrypt_mode};
      default:                     prdata = '0;
    endcase
  end

endmodule

FILE: rtl/tagc_rank.sv
// ----------------------------------------------------------------------------
// tagc_rank
// Rank lanes: one counter per password byte, fed one password byte a cycle,
// giving the stable signed sort order of the block's password prefix.
// ----------------------------------------------------------------------------
module tagc_rank (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tagc_pkg::LEN_W-1:0]    len,
  input  logic [tagc_pkg::PW_W-1:0]     password,
  input  logic [tagc_pkg::IDX_W-1:0]    pos,
  output logic                          done,
  output logic [tagc_pkg::IDX_W-1:0]    key_idx,
  output logic [tagc_pkg::IDX_W-1:0]    rank_sel
);

  logic                         busy;
  logic [tagc_pkg::IDX_W-1:0]   step;
  logic [tagc_pkg::PW_W-1:0]    sh;
  logic [tagc_pkg::IDX_W-1:0]   rank_r [tagc_pkg::MAX_PASS_LEN];
  logic                         last_step;

  assign last_step = ({1'b0, step} == len - tagc_pkg::LEN_W'(1));

  // Sequence the pass over the password prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift the password past the lanes and advance the counters
  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      sh   <= password;
      for (int j = 0; j < tagc_pkg::MAX_PASS_LEN; j++) begin
        rank_r[j] <= '0;
      end
    end else if (busy) begin
      step <= step + tagc_pkg::IDX_W'(1);
      sh   <= sh >> 8;
      for (int j = 0; j < tagc_pkg::MAX_PASS_LEN; j++) begin
        if (($signed(sh[7:0]) < $signed(password[8*j +: 8])) ||
            ((sh[7:0] == password[8*j +: 8]) && (step < tagc_pkg::IDX_W'(j)))) begin
          rank_r[j] <= rank_r[j] + tagc_pkg::IDX_W'(1);
        end
      end
    end
  end

  // Inverse lookup: which byte of the block goes to output position pos
  always_comb begin
    key_idx = '0;
    for (int j = 0; j < tagc_pkg::MAX_PASS_LEN; j++) begin
      if ((tagc_pkg::LEN_W'(j) < len) && (rank_r[j] == pos)) begin
        key_idx = key_idx | tagc_pkg::IDX_W'(j);
      end
    end
  end

  assign rank_sel = rank_r[pos];

endmodule

FILE: rtl/tagc_outq.sv
// ----------------------------------------------------------------------------
// tagc_outq
// Two-entry result queue in front of the result channel.
// ----------------------------------------------------------------------------
module tagc_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tagc_pkg::res_t push_data,
  input  logic           pop,
  output logic [1:0]     count,
  output tagc_pkg::res_t head
);

  tagc_pkg::res_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign head = entry[rd_ptr];

endmodule

FILE: rtl/tagc_check.sv
// ----------------------------------------------------------------------------
// tagc_check
// Port-level checks of the cipher block, bound to the top level.
// ----------------------------------------------------------------------------
module tagc_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         msg_valid,
  input logic                         msg_stall,
  input tagc_pkg::msg_t               msg,
  input logic                         res_valid,
  input logic                         res_stall,
  input tagc_pkg::res_t               res
);

  // The end of a message also ends a block
  a_msg_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.message_last || res.run_last))
    else $error("message_last without run_last");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // A message end flushes a block, so input is held off next
  a_eom_flush: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && !msg_stall && msg.end_of_message) |=> msg_stall)
    else $error("input taken right after end of message");

endmodule

bind transposition_additive_gamma_cipher tagc_check u_check (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_stall (msg_stall),
  .msg       (msg),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
